// ===== sv/cgmp_pkg.sv =====
`default_nettype none

package cgmp_pkg;

    // field widths
    localparam int COST_W    = 16;
    localparam int MIN_W     = 26;
    localparam int BEST_W    = 27;
    localparam int NROWS_W   = 7;
    localparam int NCOLS_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

    // running best cost of a path ending at one row
    typedef logic signed [BEST_W-1:0] t_best;

    // largest positive best cost, start value of the running minimum
    localparam t_best BEST_RESET = t_best'(27'sh3FF_FFFF);

endpackage

`default_nettype wire

// ===== sv/cgmp_col_buf.sv =====
`default_nettype none

module cgmp_col_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire cgmp_pkg::t_best i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output cgmp_pkg::t_best      o_rd_data
);
    import cgmp_pkg::*;

    t_best r_mem [DEPTH];
    t_best r_rd_data;

    // column buffer write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/cyclic_grid_min_path_cost.sv =====
// Least-cost path across a grid whose rows wrap top to bottom.
// Set num_rows (index 0) and num_cols (index 1) on the cfg channel while the
// block is idle; any write drops a matrix in progress. Zero counts act as one,
// counts above MAX_ROWS / MAX_COLS act as the maximum.
// Cells enter on s_axis one per word, column-major: all rows of column 0,
// then column 1 and so on. One result word leaves on m_axis after the last
// cell of each matrix and carries the least path cost.
// Throughput: one cell per clock, set by the single compute stage that reads
// the previous column from one buffer port and a small window of registers,
// except while a final cell waits behind a result still in the output register.
// The final cell's result passes from the compute stage into that register.
// A finished result waits in the output register while m_axis_tready is low;
// cells keep flowing until the next matrix's final cell needs that register.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets both counts to
// one and restarts at the first cell. Column buffer contents are not cleared;
// every entry is written before it is read.
`default_nettype none

module cyclic_grid_min_path_cost #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // cfg write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [cgmp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cgmp_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // cell stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [cgmp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] cell_cost
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [cgmp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata   // [25:0] least_cost
);
    import cgmp_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    // configuration
    logic [NROWS_W-1:0] r_num_rows;
    logic [NCOLS_W-1:0] r_num_cols;
    logic [RCW-1:0]     rows_used;
    logic [CCW-1:0]     cols_used;
    logic               cfg_wr;

    // position of the next cell to accept
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic          row_last;
    logic          col_last;
    logic [RW-1:0] rd_addr;
    logic          in_acc;

    // compute stage
    logic                     r_a_valid;
    logic                     n_a_valid;
    logic signed [COST_W-1:0] r_a_cost;
    logic [RW-1:0]            r_a_row;
    logic                     r_a_row_zero;
    logic                     r_a_last_row;
    logic                     r_a_first_col;
    logic                     r_a_last_col;
    logic                     r_a_emit;
    logic                     r_a_fwd;
    t_best                    r_a_fwd_val;
    logic                     a_advance;

    // previous column window
    t_best r_win_up;
    t_best r_win_mid;
    t_best r_prev0;
    t_best r_best0;
    t_best buf_rd;
    t_best a_dn;
    t_best a_min_um;
    t_best a_min;
    t_best a_cost_ext;
    t_best a_best;

    // running minimum and result
    t_best r_run;
    t_best n_run;
    t_best a_run_min;
    logic  r_o_valid;
    logic [MIN_W-1:0] r_o_min;

    // counts in use
    always_comb begin
        if (r_num_rows == '0) begin
            rows_used = RCW'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_used = RCW'(MAX_ROWS);
        end else begin
            rows_used = RCW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            cols_used = CCW'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_used = CCW'(MAX_COLS);
        end else begin
            cols_used = CCW'(r_num_cols);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NROWS_W'(1);
            r_num_cols <= NCOLS_W'(1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_NUM_ROWS: r_num_rows <= i_cfg_data[NROWS_W-1:0];
                REG_NUM_COLS: r_num_cols <= i_cfg_data[NCOLS_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: stage frees when its word finishes
    assign a_advance     = r_a_valid && (!r_a_emit || !r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // position bookkeeping
    assign row_last = (RCW'(r_row) + RCW'(1)) >= rows_used;
    assign col_last = (CCW'(r_col) + CCW'(1)) >= cols_used;
    assign rd_addr  = row_last ? '0 : RW'(RCW'(r_row) + RCW'(1));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (cfg_wr) begin
            n_row = '0;
            n_col = '0;
        end else if (in_acc) begin
            if (row_last) begin
                n_row = '0;
                n_col = col_last ? '0 : CW'(CCW'(r_col) + CCW'(1));
            end else begin
                n_row = RW'(RCW'(r_row) + RCW'(1));
            end
        end
    end

    assign n_a_valid = in_acc ? 1'b1 : (a_advance ? 1'b0 : r_a_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_a_valid <= n_a_valid;
        end
    end

    // capture cell and its position flags
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cost      <= signed'(s_axis_tdata[COST_W-1:0]);
            r_a_row       <= r_row;
            r_a_row_zero  <= (r_row == '0);
            r_a_last_row  <= row_last;
            r_a_first_col <= (r_col == '0);
            r_a_last_col  <= col_last;
            r_a_emit      <= row_last && col_last;
            r_a_fwd       <= a_advance && (r_a_row == rd_addr);
            r_a_fwd_val   <= a_best;
        end
    end

    // previous column buffer, one entry per row
    cgmp_col_buf #(
        .DEPTH (MAX_ROWS),
        .AW    (RW)
    ) u_col_buf (
        .i_clk     (i_clk),
        .i_wr_en   (a_advance),
        .i_wr_addr (r_a_row),
        .i_wr_data (a_best),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (buf_rd)
    );

    // neighbour below: wrap to row 0, or buffer word with bypass
    always_comb begin
        if (r_a_last_row) begin
            a_dn = r_a_row_zero ? r_win_mid : r_prev0;
        end else begin
            a_dn = r_a_fwd ? r_a_fwd_val : buf_rd;
        end
    end

    // three-way minimum and add
    assign a_min_um   = (r_win_up < r_win_mid) ? r_win_up : r_win_mid;
    assign a_min      = (a_dn < a_min_um) ? a_dn : a_min_um;
    assign a_cost_ext = {{(BEST_W-COST_W){r_a_cost[COST_W-1]}}, r_a_cost};
    assign a_best     = r_a_first_col ? a_cost_ext : a_cost_ext + a_min;

    // slide the window one row on
    always_ff @(posedge i_clk) begin
        if (a_advance) begin
            r_win_up <= r_a_last_row ? a_best : r_win_mid;
            if (r_a_last_row) begin
                r_win_mid <= r_a_row_zero ? a_best : r_best0;
            end else begin
                r_win_mid <= a_dn;
            end
            if (r_a_row_zero) begin
                r_prev0 <= r_win_mid;
                r_best0 <= a_best;
            end
        end
    end

    // running minimum over the last column
    assign a_run_min = (r_a_last_col && (a_best < r_run)) ? a_best : r_run;

    always_comb begin
        n_run = r_run;
        if (cfg_wr) begin
            n_run = BEST_RESET;
        end else if (a_advance) begin
            n_run = r_a_emit ? BEST_RESET : a_run_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= BEST_RESET;
        end else begin
            r_run <= n_run;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_advance && r_a_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance && r_a_emit) begin
            r_o_min <= a_run_min[MIN_W-1:0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-MIN_W){1'b0}}, r_o_min};

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_valid && r_a_emit && r_o_valid && !m_axis_tready))
        else $error("input stalled without a waiting result");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RCW'(r_row) < rows_used))
        else $error("row position beyond rows in use");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_advance && r_a_emit) |=> m_axis_tvalid)
        else $error("final cell did not load a result");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_advance) |=> (r_a_valid && $stable(r_a_cost)))
        else $error("held word lost from compute stage");

endmodule

`default_nettype wire

// ===== tb/cyclic_grid_min_path_cost_test.sv =====
`timescale 1ns / 100ps

module cyclic_grid_min_path_cost_test;

    import cgmp_pkg::*;

    localparam int MAX_ROWS         = 64;
    localparam int MAX_COLS         = 1024;
    localparam int CELLS_TARGET     = 1750;
    localparam int MATRICES_TARGET  = 40;
    localparam int DRAIN_CYCLES     = 6;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = REG_NUM_ROWS;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    cyclic_grid_min_path_cost #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // cells waiting to be driven, least path costs still owed by the block
    logic [COST_W-1:0] cell_queue[$];
    logic [MIN_W-1:0]  expected_min[$];
    int                mismatches = 0;
    int                cycle_count = 0;
    int                hold_asks = 0;

    // shadow of the grid size and column buffers
    logic [NROWS_W-1:0] rows_set;
    logic [NCOLS_W-1:0] cols_set;
    t_best              prev_best [MAX_ROWS];
    t_best              cur_best  [MAX_ROWS];
    int unsigned        row_at;
    int unsigned        col_at;
    t_best              least_cost;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void restart_matrix();
        row_at     = 0;
        col_at     = 0;
        least_cost = BEST_RESET;
    endfunction

    function automatic void set_grid_size(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] val);
        if (idx == REG_NUM_ROWS) begin
            rows_set = val[NROWS_W-1:0];
            restart_matrix();
        end else if (idx == REG_NUM_COLS) begin
            cols_set = val[NCOLS_W-1:0];
            restart_matrix();
        end
    endfunction

    function automatic int unsigned clamp_count(input int unsigned n, input int unsigned top);
        if (n == 0)
            return 1;
        return (n > top) ? top : n;
    endfunction

    // one cell through the column recurrence; owes a result after the last cell
    function automatic void advance_path_cost(input logic [COST_W-1:0] word);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned up;
        int unsigned dn;
        t_best       cost;
        t_best       best;
        t_best       m;
        bit          last_col;
        rows = clamp_count(32'(rows_set), MAX_ROWS);
        cols = clamp_count(32'(cols_set), MAX_COLS);
        cost = t_best'($signed(word));
        r = row_at;
        c = col_at;
        if (r >= rows)
            r = 0;
        if (c >= cols)
            c = 0;
        last_col = (c + 1 >= cols);
        if (c == 0) begin
            best = cost;
        end else begin
            up = (r == 0) ? rows - 1 : r - 1;
            dn = (r + 1 >= rows) ? 0 : r + 1;
            m = prev_best[r];
            if (prev_best[up] < m)
                m = prev_best[up];
            if (prev_best[dn] < m)
                m = prev_best[dn];
            best = cost + m;
        end
        cur_best[r] = best;
        if (last_col && best < least_cost)
            least_cost = best;
        r++;
        if (r >= rows) begin
            r = 0;
            if (last_col) begin
                expected_min.push_back(least_cost[MIN_W-1:0]);
                restart_matrix();
                return;
            end
            prev_best = cur_best;
            c++;
        end
        row_at = r;
        col_at = c;
    endfunction

    // cell driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                advance_path_cost(s_axis_tdata[COST_W-1:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cell_queue.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cell_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: own stall pattern, long hold-off on request
    int hold_left = 0;
    int hold_served = 0;
    int ready_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        logic [MIN_W-1:0] got;
        logic [MIN_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[MIN_W-1:0];
                if (expected_min.size() == 0) begin
                    report_mismatch($sformatf("least cost %0d with no result owed",
                                              $signed(got)));
                end else begin
                    want = expected_min.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf("least cost got %0d want %0d",
                                                  $signed(got), $signed(want)));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_served != hold_asks) begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        set_grid_size(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds back until nothing is in flight
    task automatic wait_quiet();
        while (cell_queue.size() != 0 || s_axis_tvalid || expected_min.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return COST_W'($signed($urandom_range(0, 6)) - 3);
            default: return COST_W'($urandom());
        endcase
    endfunction

    int unsigned cells_planned = 0;
    int unsigned matrices_planned = 0;

    task automatic queue_cells(input int unsigned n, input bit all_min);
        repeat (n) begin
            cell_queue.push_back(all_min ? 16'h8000 : pick_cost());
            cells_planned++;
        end
    endtask

    initial begin
        logic [CFG_DAT_W-1:0] rows_data;
        logic [CFG_DAT_W-1:0] cols_data;
        int unsigned          n_cells;
        int unsigned          n_mats;
        int unsigned          phase_no;
        bit                   all_min;
        bit                   want_hold;
        bit                   broken;

        rows_set = NROWS_W'(1);
        cols_set = NCOLS_W'(1);
        restart_matrix();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size is one cell per matrix: cost extremes straight through
        cell_queue.push_back(16'h8000);
        cell_queue.push_back(16'h7FFF);
        cell_queue.push_back(16'h0000);
        cell_queue.push_back(16'hFFFF);
        wait_quiet();

        // row count with only high bits set and zero columns both act as one
        write_reg(REG_NUM_ROWS, 11'h080);
        write_reg(REG_NUM_COLS, 11'd0);
        cell_queue.push_back(16'h5555);
        cell_queue.push_back(16'hAAAA);
        wait_quiet();

        // two rows, each neighbour is the other row
        write_reg(REG_NUM_ROWS, 11'd2);
        write_reg(REG_NUM_COLS, 11'd3);
        queue_cells(6, 1'b0);
        wait_quiet();

        // single row, neighbours are the row itself
        write_reg(REG_NUM_ROWS, 11'd1);
        write_reg(REG_NUM_COLS, 11'd2);
        queue_cells(2, 1'b0);
        wait_quiet();

        // part of a matrix (four of its six cells), then a write drops it
        write_reg(REG_NUM_ROWS, 11'd3);
        queue_cells(4, 1'b0);
        wait_quiet();
        write_reg(REG_NUM_ROWS, 11'd3);
        queue_cells(6, 1'b0);
        wait_quiet();

        // random phases, each a fresh grid size
        phase_no = 0;
        while (cells_planned < CELLS_TARGET || matrices_planned < MATRICES_TARGET) begin
            all_min = 1'b0;
            want_hold = 1'b0;
            broken = 1'b0;
            case (phase_no)
                0: begin
                    rows_data = 11'd64;
                    cols_data = 11'd2;
                    n_mats = 1;
                end
                1: begin
                    // rows above the maximum clamp
                    rows_data = 11'h07F;
                    cols_data = 11'd1;
                    n_mats = 2;
                end
                2: begin
                    // longest path, every cell at the most negative cost
                    rows_data = 11'h781;
                    cols_data = 11'h7FF;
                    n_mats = 1;
                    all_min = 1'b1;
                end
                3: begin
                    // tiny matrices while the receiver holds off
                    rows_data = CFG_DAT_W'($urandom_range(1, 4));
                    cols_data = CFG_DAT_W'($urandom_range(1, 3));
                    n_mats = 30;
                    want_hold = 1'b1;
                end
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        rows_data = CFG_DAT_W'($urandom_range(0, 2047));
                        cols_data = CFG_DAT_W'($urandom_range(0, 2));
                    end else begin
                        rows_data = CFG_DAT_W'($urandom_range(0, 8));
                        cols_data = CFG_DAT_W'($urandom_range(0, 8));
                    end
                    n_mats = $urandom_range(1, 6);
                    broken = ($urandom_range(0, 3) == 0);
                    want_hold = ($urandom_range(0, 7) == 0);
                end
            endcase
            write_reg(REG_NUM_ROWS, rows_data);
            write_reg(REG_NUM_COLS, cols_data);
            n_cells = clamp_count(32'(rows_data[NROWS_W-1:0]), MAX_ROWS) *
                      clamp_count(32'(cols_data), MAX_COLS);
            if (want_hold)
                hold_asks <= hold_asks + 1;
            queue_cells(n_cells * n_mats, all_min);
            matrices_planned += n_mats;
            if (broken && n_cells > 1)
                queue_cells($urandom_range(1, n_cells - 1), 1'b0);
            wait_quiet();
            phase_no++;
        end

        wait_quiet();
        if (mismatches == 0 && expected_min.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cgmp_pkg.sv
sv/cgmp_col_buf.sv
sv/cyclic_grid_min_path_cost.sv
tb/cyclic_grid_min_path_cost_test.sv
